// ===== rtl/imav_pkg.sv =====
// shared constants and types for the imu moving average block
package imav_pkg;

	localparam int SAMPLE_W = 16;
	localparam int NUM_AXES = 3;
	localparam int NUM_CH   = 2 * NUM_AXES;
	localparam int WINDOW   = 10;
	localparam int LOG_W    = $clog2(WINDOW);

	// running sum spans at most WINDOW * 2^15 in magnitude
	localparam int SUM_W   = SAMPLE_W + LOG_W;
	// reciprocal multiply: floor(n / WINDOW) == (n * RECIP) >> SHIFT for n < 2^SUM_W
	localparam int SHIFT   = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam int QUO_W = SAMPLE_W + 1;
	localparam int RES_W = SAMPLE_W + 2;

	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_GYRO_OFFSET_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_GYRO_OFFSET_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_GYRO_OFFSET_Z = 2'd2;

	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] set_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
	} lane_ctrl_t;

endpackage

// ===== rtl/imav_cell.sv =====
// one window slot: holds a six-channel sample set and passes it on at each transfer
module imav_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  imav_pkg::set_t d,
	output imav_pkg::set_t q
);

	imav_pkg::set_t set_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= '0;
		end else if (shift) begin
			set_q <= d;
		end
	end

	assign q = set_q;

endmodule

// ===== rtl/imav_lane.sv =====
// per-channel running sum, divide by window, offset subtract and saturation
module imav_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  imav_pkg::lane_ctrl_t                 ctrl,
	input  logic signed [imav_pkg::SAMPLE_W-1:0] sample_new,
	input  logic signed [imav_pkg::SAMPLE_W-1:0] sample_old,
	input  logic signed [imav_pkg::SAMPLE_W-1:0] offset,
	output logic signed [imav_pkg::SAMPLE_W-1:0] result
);

	logic signed [imav_pkg::SUM_W-1:0]  sum_q;
	logic signed [imav_pkg::SUM_W-1:0]  sum_nxt;
	logic signed [imav_pkg::SUM_W-1:0]  sum_s1;
	logic        [imav_pkg::SUM_W-1:0]  mag;
	logic        [imav_pkg::PROD_W-1:0] prod_s2;
	logic                               neg_s2;
	logic        [imav_pkg::QUO_W-1:0]  quo;
	logic signed [imav_pkg::RES_W-1:0]  mean;
	logic signed [imav_pkg::RES_W-1:0]  diff;
	logic signed [imav_pkg::SAMPLE_W-1:0] sat;
	logic signed [imav_pkg::SAMPLE_W-1:0] result_s3;

	assign sum_nxt = sum_q + imav_pkg::SUM_W'(sample_new) - imav_pkg::SUM_W'(sample_old);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.load_s1) begin
			sum_q <= sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			sum_s1 <= sum_nxt;
		end
	end

	// magnitude so the reciprocal multiply truncates toward zero
	assign mag = sum_s1[imav_pkg::SUM_W-1] ? imav_pkg::SUM_W'(-sum_s1)
		: imav_pkg::SUM_W'(sum_s1);

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			prod_s2 <= imav_pkg::PROD_W'(mag) * imav_pkg::PROD_W'(imav_pkg::RECIP);
			neg_s2  <= sum_s1[imav_pkg::SUM_W-1];
		end
	end

	assign quo  = prod_s2[imav_pkg::SHIFT +: imav_pkg::QUO_W];
	assign mean = neg_s2 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign diff = mean - imav_pkg::RES_W'(offset);

	always_comb begin
		if (diff > imav_pkg::RES_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (diff < -imav_pkg::RES_W'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = diff[imav_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			result_s3 <= sat;
		end
	end

	assign result = result_s3;

endmodule

// ===== rtl/imu_moving_average_offset.sv =====
// top level: boxcar mean of six imu channels with gyro offset correction
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | accel_{x,y,z}_raw, gyro_{x,y,z}_raw
//  out     | out_valid / out_stall| accel_{x,y,z}_mean, gyro_{x,y,z}_corrected
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one sample set per cycle while the output does not stall; each result passes in
// order through the registered stages before it is on the outputs
// (running sum, reciprocal multiply, offset and saturation stages)
// the window is a row of cells shifted at each input transfer; the last cell is
// the sample that leaves the running sum
// reset clears all cells, the sums and the offsets at once
// while the output stalls, the empty stages keep taking transfers, up to three
module imu_moving_average_offset (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [imav_pkg::SAMPLE_W-1:0]  accel_x_raw,
	input  logic signed [imav_pkg::SAMPLE_W-1:0]  accel_y_raw,
	input  logic signed [imav_pkg::SAMPLE_W-1:0]  accel_z_raw,
	input  logic signed [imav_pkg::SAMPLE_W-1:0]  gyro_x_raw,
	input  logic signed [imav_pkg::SAMPLE_W-1:0]  gyro_y_raw,
	input  logic signed [imav_pkg::SAMPLE_W-1:0]  gyro_z_raw,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [imav_pkg::SAMPLE_W-1:0]  accel_x_mean,
	output logic signed [imav_pkg::SAMPLE_W-1:0]  accel_y_mean,
	output logic signed [imav_pkg::SAMPLE_W-1:0]  accel_z_mean,
	output logic signed [imav_pkg::SAMPLE_W-1:0]  gyro_x_corrected,
	output logic signed [imav_pkg::SAMPLE_W-1:0]  gyro_y_corrected,
	output logic signed [imav_pkg::SAMPLE_W-1:0]  gyro_z_corrected,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [imav_pkg::IDX_W-1:0]     cfg_index,
	input  logic        [imav_pkg::SAMPLE_W-1:0]  cfg_data
);

	imav_pkg::set_t       chain [imav_pkg::WINDOW+1];
	imav_pkg::lane_ctrl_t ctrl;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_offset_q [imav_pkg::NUM_AXES];
	logic signed [imav_pkg::SAMPLE_W-1:0] res [imav_pkg::NUM_CH];
	logic accept;
	logic v_s1;
	logic v_s2;
	logic v_s3;

	// each stage moves when the next one is empty or moving too
	assign ctrl.load_s3 = v_s2 && (!v_s3 || !out_stall);
	assign ctrl.load_s2 = v_s1 && (!v_s2 || ctrl.load_s3);
	assign in_stall     = v_s1 && !ctrl.load_s2;
	assign accept       = in_valid && !in_stall;
	assign ctrl.load_s1 = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (ctrl.load_s2) begin
				v_s1 <= 1'b0;
			end
			if (ctrl.load_s2) begin
				v_s2 <= 1'b1;
			end else if (ctrl.load_s3) begin
				v_s2 <= 1'b0;
			end
			if (ctrl.load_s3) begin
				v_s3 <= 1'b1;
			end else if (!out_stall) begin
				v_s3 <= 1'b0;
			end
		end
	end

	assign out_valid = v_s3;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < imav_pkg::NUM_AXES; i++) begin
				gyro_offset_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				imav_pkg::REG_GYRO_OFFSET_X: gyro_offset_q[0] <= cfg_data;
				imav_pkg::REG_GYRO_OFFSET_Y: gyro_offset_q[1] <= cfg_data;
				imav_pkg::REG_GYRO_OFFSET_Z: gyro_offset_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// window of cells, newest at the front
	assign chain[0] = {gyro_z_raw, gyro_y_raw, gyro_x_raw,
		accel_z_raw, accel_y_raw, accel_x_raw};

	for (genvar k = 0; k < imav_pkg::WINDOW; k++) begin : g_cell
		imav_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (accept),
			.d      (chain[k]),
			.q      (chain[k+1])
		);
	end

	for (genvar c = 0; c < imav_pkg::NUM_CH; c++) begin : g_lane
		logic signed [imav_pkg::SAMPLE_W-1:0] lane_offset;
		if (c < imav_pkg::NUM_AXES) begin : g_accel
			assign lane_offset = '0;
		end else begin : g_gyro
			assign lane_offset = gyro_offset_q[c - imav_pkg::NUM_AXES];
		end
		imav_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample_new (chain[0][c]),
			.sample_old (chain[imav_pkg::WINDOW][c]),
			.offset     (lane_offset),
			.result     (res[c])
		);
	end

	assign accel_x_mean     = res[0];
	assign accel_y_mean     = res[1];
	assign accel_z_mean     = res[2];
	assign gyro_x_corrected = res[3];
	assign gyro_y_corrected = res[4];
	assign gyro_z_corrected = res[5];

`ifndef SYNTHESIS
	// an empty front stage never pushes back
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with empty front stage");

	// a waiting result is not dropped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_stall) |=> v_s3)
		else $error("stalled result lost");

	// a transfer always lands in the front stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted sample set not held");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the imu moving average block with gyro offset correction
module tb;

	localparam int S16_MAX = 32767;
	localparam int S16_MIN = -32768;
	localparam int RANDOM_PHASES = 6;
	localparam int SETS_PER_PHASE = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int PIPE_DEPTH = 3;
	localparam int MAX_REPORTS = 20;
	localparam logic [imav_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [imav_pkg::SAMPLE_W-1:0] accel_x_raw = '0;
	logic signed [imav_pkg::SAMPLE_W-1:0] accel_y_raw = '0;
	logic signed [imav_pkg::SAMPLE_W-1:0] accel_z_raw = '0;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_x_raw = '0;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_y_raw = '0;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_z_raw = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [imav_pkg::SAMPLE_W-1:0] accel_x_mean;
	logic signed [imav_pkg::SAMPLE_W-1:0] accel_y_mean;
	logic signed [imav_pkg::SAMPLE_W-1:0] accel_z_mean;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_x_corrected;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_y_corrected;
	logic signed [imav_pkg::SAMPLE_W-1:0] gyro_z_corrected;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [imav_pkg::IDX_W-1:0] cfg_index = '0;
	logic [imav_pkg::SAMPLE_W-1:0] cfg_data = '0;

	imu_moving_average_offset u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.accel_x_raw      (accel_x_raw),
		.accel_y_raw      (accel_y_raw),
		.accel_z_raw      (accel_z_raw),
		.gyro_x_raw       (gyro_x_raw),
		.gyro_y_raw       (gyro_y_raw),
		.gyro_z_raw       (gyro_z_raw),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.accel_x_mean     (accel_x_mean),
		.accel_y_mean     (accel_y_mean),
		.accel_z_mean     (accel_z_mean),
		.gyro_x_corrected (gyro_x_corrected),
		.gyro_y_corrected (gyro_y_corrected),
		.gyro_z_corrected (gyro_z_corrected),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// channel order: accel x y z, then gyro x y z
	string chan_name [imav_pkg::NUM_CH] = '{"accel_x_mean", "accel_y_mean", "accel_z_mean",
		"gyro_x_corrected", "gyro_y_corrected", "gyro_z_corrected"};

	imav_pkg::set_t pending_sets[$];
	imav_pkg::set_t expected_means[$];

	// predictor state
	int window_ring [imav_pkg::NUM_CH][imav_pkg::WINDOW];
	int running_sum [imav_pkg::NUM_CH];
	int ring_pos;
	int gyro_bias [imav_pkg::NUM_AXES];

	int in_hold;
	int stall_hold;
	bit in_fired;
	bit quiet;
	int idle_cycles;
	int sets_in;
	int results_checked;
	int reg_writes;
	int settings_used;
	int mismatches;
	imav_pkg::set_t next_set;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic imav_pkg::set_t window_mean(input imav_pkg::set_t s);
		imav_pkg::set_t r;
		int v;
		int m;
		for (int c = 0; c < imav_pkg::NUM_CH; c++) begin
			v = int'($signed(s[c]));
			running_sum[c] += v - window_ring[c][ring_pos];
			window_ring[c][ring_pos] = v;
		end
		ring_pos = (ring_pos + 1) % imav_pkg::WINDOW;
		for (int c = 0; c < imav_pkg::NUM_AXES; c++) begin
			r[c] = imav_pkg::SAMPLE_W'(running_sum[c] / imav_pkg::WINDOW);
			m = running_sum[c + imav_pkg::NUM_AXES] / imav_pkg::WINDOW - gyro_bias[c];
			if (m > S16_MAX)
				m = S16_MAX;
			else if (m < S16_MIN)
				m = S16_MIN;
			r[c + imav_pkg::NUM_AXES] = imav_pkg::SAMPLE_W'(m);
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic imav_pkg::set_t random_set();
		imav_pkg::set_t s;
		int mode;
		mode = $urandom_range(0, 9);
		for (int c = 0; c < imav_pkg::NUM_CH; c++) begin
			if (mode < 5)
				s[c] = imav_pkg::SAMPLE_W'($urandom);
			else if (mode < 7)
				s[c] = imav_pkg::SAMPLE_W'(int'($urandom_range(0, 40)) - 20);
			else if (mode == 7)
				s[c] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			else if (mode == 8)
				s[c] = imav_pkg::SAMPLE_W'(S16_MAX - int'($urandom_range(0, 64)));
			else
				s[c] = imav_pkg::SAMPLE_W'(S16_MIN + int'($urandom_range(0, 64)));
		end
		return s;
	endfunction

	function automatic logic [imav_pkg::SAMPLE_W-1:0] random_offset();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return imav_pkg::SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
			default: return imav_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [imav_pkg::IDX_W-1:0] idx,
		input logic [imav_pkg::SAMPLE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_sets.size() != 0 || in_valid || expected_means.size() != 0);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fired) begin
			if (in_hold > 0) begin
				in_hold <= in_hold - 1;
				in_valid <= 1'b0;
			end else if (pending_sets.size() != 0) begin
				next_set = pending_sets.pop_front();
				accel_x_raw <= next_set[0];
				accel_y_raw <= next_set[1];
				accel_z_raw <= next_set[2];
				gyro_x_raw <= next_set[3];
				gyro_y_raw <= next_set[4];
				gyro_z_raw <= next_set[5];
				in_valid <= 1'b1;
				in_hold <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold <= stall_hold - 1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				stall_hold <= pick_gap();
		end
	end

	// monitor, predictor update and watchdog
	always @(posedge clk) begin
		imav_pkg::set_t got;
		imav_pkg::set_t want;
		bit moved;
		moved = 1'b0;
		in_fired = in_valid && !in_stall;
		if (arst_n && cfg_valid && cfg_ready) begin
			moved = 1'b1;
			reg_writes++;
			case (cfg_index)
				imav_pkg::REG_GYRO_OFFSET_X: gyro_bias[0] = int'($signed(cfg_data));
				imav_pkg::REG_GYRO_OFFSET_Y: gyro_bias[1] = int'($signed(cfg_data));
				imav_pkg::REG_GYRO_OFFSET_Z: gyro_bias[2] = int'($signed(cfg_data));
				default: ;
			endcase
		end
		if (arst_n && in_fired) begin
			moved = 1'b1;
			sets_in++;
			expected_means.push_back(window_mean({gyro_z_raw, gyro_y_raw, gyro_x_raw,
				accel_z_raw, accel_y_raw, accel_x_raw}));
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			got = {gyro_z_corrected, gyro_y_corrected, gyro_x_corrected,
				accel_z_mean, accel_y_mean, accel_x_mean};
			if (expected_means.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result transfer with nothing expected, got %h", $time, got);
			end else begin
				want = expected_means.pop_front();
				results_checked++;
				for (int c = 0; c < imav_pkg::NUM_CH; c++) begin
					if (got[c] !== want[c]) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: %s expected %0d, got %0d", $time, chan_name[c],
								$signed(want[c]), $signed(got[c]));
					end
				end
			end
		end
		if (!arst_n || moved)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < imav_pkg::NUM_CH; c++) begin
			running_sum[c] = 0;
			for (int s = 0; s < imav_pkg::WINDOW; s++)
				window_ring[c][s] = 0;
		end
		for (int c = 0; c < imav_pkg::NUM_AXES; c++)
			gyro_bias[c] = 0;
		ring_pos = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extreme offsets so the gyro path saturates both ways
		write_reg(imav_pkg::REG_GYRO_OFFSET_X, 16'h8000);
		write_reg(imav_pkg::REG_GYRO_OFFSET_Y, 16'h7fff);
		write_reg(imav_pkg::REG_GYRO_OFFSET_Z, 16'h0001);
		write_reg(REG_UNUSED, 16'h5a5a);
		end_writes();

		// filling window from empty, then full at both rails, then odd sums
		repeat (imav_pkg::WINDOW) pending_sets.push_back({imav_pkg::NUM_CH{16'h7fff}});
		repeat (imav_pkg::WINDOW) pending_sets.push_back({imav_pkg::NUM_CH{16'h8000}});
		pending_sets.push_back({16'h0001, 16'hffff, 16'h0000, 16'hfff1, 16'h000f, 16'h8000});
		pending_sets.push_back({16'hfff9, 16'h0007, 16'h8001, 16'h7ffe, 16'hffff, 16'h0003});
		pending_sets.push_back({imav_pkg::NUM_CH{16'hfffd}});
		pending_sets.push_back({imav_pkg::NUM_CH{16'h0000}});
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			quiet = (p == 2);
			write_reg(imav_pkg::REG_GYRO_OFFSET_X, random_offset());
			write_reg(imav_pkg::REG_GYRO_OFFSET_Y, random_offset());
			write_reg(imav_pkg::REG_GYRO_OFFSET_Z, random_offset());
			if ($urandom_range(0, 1))
				write_reg(REG_UNUSED, imav_pkg::SAMPLE_W'($urandom));
			end_writes();
			repeat (SETS_PER_PHASE) pending_sets.push_back(random_set());
			drain();
		end

		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (expected_means.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time, expected_means.size());
		end
		$display("%0d sample sets in, %0d results checked, %0d mismatching fields",
			sets_in, results_checked, mismatches);
		$display("%0d register writes over %0d offset settings", reg_writes, settings_used);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/imav_pkg.sv
rtl/imav_cell.sv
rtl/imav_lane.sv
rtl/imu_moving_average_offset.sv
dv/tb.sv
